// ----- rtl/leb_pkg.sv -----
// Shared types and constants for the line edit buffer.
// No dependencies; imported by every module of the block.
package leb_pkg;

    localparam int LINE_DEPTH_DEF = 62;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] ERASE_RESET  = 8'd35;
    localparam logic [7:0] KILL_RESET   = 8'd64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 2'd1;

    typedef enum logic [1:0] {
        LOAD_NONE,
        LOAD_STORE,
        LOAD_NL,
        LOAD_NL_LAST
    } load_kind_t;

    typedef struct packed {
        logic       edit;
        logic       ptr_clr;
        logic       rd_en;
        logic       ptr_inc;
        load_kind_t load;
        logic       clear_line;
    } cmd_t;

    typedef struct packed {
        logic flush;
        logic fill_zero;
        logic ptr_last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/leb_ctrl.sv -----
// Flush sequencer state machine for the line edit buffer.
// Depends on leb_pkg; drives the datapath through cmd_t, reads status_t.
module leb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  leb_pkg::status_t status,
    output leb_pkg::cmd_t    cmd
);
    import leb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_NL1,
        S_NL2
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.load       = LOAD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.flush)
                    begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = status.fill_zero ? S_NL1 : S_READ;
                    end
                    else
                    begin
                        cmd.edit = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load    = LOAD_STORE;
                    cmd.ptr_inc = 1'b1;
                    state_next  = status.ptr_last ? S_NL1 : S_READ;
                end
            end
            S_NL1:
            begin
                if (status.out_free)
                begin
                    cmd.load   = LOAD_NL;
                    state_next = S_NL2;
                end
            end
            S_NL2:
            begin
                if (status.out_free)
                begin
                    cmd.load       = LOAD_NL_LAST;
                    cmd.clear_line = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/leb_datapath.sv -----
// Line store, fill count, flags, config registers and output register.
// Depends on leb_pkg; commanded by leb_ctrl through cmd_t.
module leb_datapath #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser,
    input  leb_pkg::cmd_t                 cmd,
    output leb_pkg::status_t              status
);
    import leb_pkg::*;

    localparam int CNT_W = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W = $clog2((LINE_DEPTH > 1) ? LINE_DEPTH : 2);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_DEPTH);

    logic [7:0]       line_mem [LINE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [7:0]       erase_reg;
    logic [7:0]       kill_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] rd_ptr_cnt;
    logic             open_reg;
    logic             open_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             push;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic             out_drop_reg;

    assign rd_ptr_cnt = CNT_W'(rd_ptr_reg);

    assign status.flush     = s_tuser ? open_reg : (s_tdata == NEWLINE_CODE);
    assign status.fill_zero = (fill_reg == '0);
    assign status.ptr_last  = ((rd_ptr_cnt + CNT_W'(1)) == fill_reg);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

    always_comb
    begin
        fill_next = fill_reg;
        open_next = open_reg;
        ovf_next  = ovf_reg;
        push      = 1'b0;
        if (cmd.clear_line)
        begin
            fill_next = '0;
            open_next = 1'b0;
            ovf_next  = 1'b0;
        end
        else if (cmd.edit && !s_tuser)
        begin
            open_next = 1'b1;
            if (s_tdata == erase_reg)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            else if (s_tdata == kill_reg)
            begin
                fill_next = '0;
            end
            else if (fill_reg < FULL)
            begin
                push      = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            line_mem[fill_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= line_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_reg     <= ERASE_RESET;
            kill_reg      <= KILL_RESET;
            fill_reg      <= '0;
            open_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_ERASE))
            begin
                erase_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_KILL))
            begin
                kill_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            open_reg <= open_next;
            ovf_reg  <= ovf_next;
            if (cmd.ptr_clr)
            begin
                rd_ptr_reg <= '0;
            end
            else if (cmd.ptr_inc && !status.ptr_last)
            begin
                rd_ptr_reg <= rd_ptr_reg + IDX_W'(1);
            end
            if (cmd.load != LOAD_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.load)
            LOAD_STORE:
            begin
                out_data_reg <= rd_data_reg;
                out_last_reg <= 1'b0;
                out_drop_reg <= 1'b0;
            end
            LOAD_NL:
            begin
                out_data_reg <= NEWLINE_CODE;
                out_last_reg <= 1'b0;
                out_drop_reg <= 1'b0;
            end
            LOAD_NL_LAST:
            begin
                out_data_reg <= NEWLINE_CODE;
                out_last_reg <= 1'b1;
                out_drop_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL)
        else $error("fill count above line depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_line |=> (fill_reg == '0) && !open_reg && !ovf_reg)
        else $error("line not cleared after flush");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load != LOAD_NONE) |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_ptr_cnt < fill_reg))
        else $error("read beyond stored bytes");

endmodule

// ----- rtl/line_edit_buffer_core.sv -----
// Line edit buffer top level: controller and datapath joined by cmd/status.
// Depends on leb_pkg, leb_ctrl and leb_datapath.
// Input: an ordinary, erase or kill byte is absorbed at one item per cycle while no flush is
// in progress. A flush emits each stored byte by a store read, then an output load, then
// the two newline bytes; output back-pressure stalls the flush.
// Reset clears state, fill count, flags, output valid and the config registers to
// their defaults; the line store is not cleared.
module line_edit_buffer_core #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tuser,   // [0] end_of_input
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    output logic                          m_tuser    // [0] dropped
);
    import leb_pkg::*;

    cmd_t    cmd;
    status_t status;

    leb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    leb_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for line_edit_buffer_core: erase, kill, flush and overflow.
// Drives bytes through the slave stream, predicts the flushed lines and checks them on
// the master stream. Depends on leb_pkg and the line edit buffer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import leb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } edit_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       dropped;
    } emit_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ERASE;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    edit_item_t pending_items[$];
    emit_t      expected_emits[$];
    edit_item_t next_item;

    // predicted line state and registers
    logic [7:0] line_model [LINE_DEPTH_DEF];
    int         fill_level    = 0;
    logic       line_begun    = 1'b0;
    logic       overflow_flag = 1'b0;
    logic [7:0] erase_reg     = ERASE_RESET;
    logic [7:0] kill_reg      = KILL_RESET;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int items_in       = 0;
    int bytes_out      = 0;
    int lines_out      = 0;
    int overflow_lines = 0;
    int settings_used  = 1;
    int quiet_cycles   = 0;

    line_edit_buffer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] in_byte
        .s_tuser   (s_tuser),   // [0] end_of_input
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] out_byte
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)    // [0] dropped
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void flush_line_model();
        int i;
        for (i = 0; i < fill_level; i++)
            expected_emits.push_back('{line_model[i], 1'b0, 1'b0});
        expected_emits.push_back('{NEWLINE_CODE, 1'b0, 1'b0});
        expected_emits.push_back('{NEWLINE_CODE, 1'b1, overflow_flag});
        fill_level    = 0;
        line_begun    = 1'b0;
        overflow_flag = 1'b0;
    endfunction

    function automatic void edit_line_model(input logic [7:0] b, input logic eoi);
        if (eoi)
        begin
            if (line_begun)
                flush_line_model();
        end
        else if (b == NEWLINE_CODE)
        begin
            flush_line_model();
        end
        else
        begin
            line_begun = 1'b1;
            if (b == erase_reg)
            begin
                if (fill_level > 0)
                    fill_level--;
            end
            else if (b == kill_reg)
            begin
                fill_level = 0;
            end
            else if (fill_level < LINE_DEPTH_DEF)
            begin
                line_model[fill_level] = b;
                fill_level++;
            end
            else
            begin
                overflow_flag = 1'b1;
            end
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.ch;
                    s_tuser  <= next_item.eoi;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        emit_t exp_emit;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ERASE)
                    erase_reg <= cfg_data;
                else if (cfg_index == CFG_KILL)
                    kill_reg <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                edit_line_model(s_tdata, s_tuser);
                items_in++;
            end
            if (m_tvalid && m_tready)
            begin
                bytes_out++;
                if (m_tlast === 1'b1)
                    lines_out++;
                if (m_tlast === 1'b1 && m_tuser === 1'b1)
                    overflow_lines++;
                if (expected_emits.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %h last %b dropped %b",
                                              m_tdata, m_tlast, m_tuser));
                end
                else
                begin
                    exp_emit = expected_emits.pop_front();
                    if (m_tdata !== exp_emit.ch)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_tdata, exp_emit.ch));
                    if (m_tlast !== exp_emit.last)
                        report_mismatch($sformatf("last %b, expected %b on byte %h",
                                                  m_tlast, exp_emit.last, exp_emit.ch));
                    if (m_tuser !== exp_emit.dropped)
                        report_mismatch($sformatf("dropped %b, expected %b on byte %h",
                                                  m_tuser, exp_emit.dropped, exp_emit.ch));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic [7:0] b, input logic eoi);
        pending_items.push_back('{b, eoi});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // hold until every item is taken and every expected byte has come
    task automatic drain_block();
        while (pending_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_emits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int queue_line(input bit long_line);
        int n;
        int k;
        int r;
        logic [7:0] b;
        n = long_line ? $urandom_range(78, 62) : $urandom_range(12, 0);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < (long_line ? 2 : 12))
                b = erase_reg;
            else if (!long_line && r < 16)
                b = kill_reg;
            else
            begin
                b = 8'($urandom_range(255));
                if (b == NEWLINE_CODE)
                    b = 8'h4A;
            end
            pending_items.push_back('{b, 1'b0});
        end
        r = $urandom_range(99);
        if (r < 80)
        begin
            pending_items.push_back('{NEWLINE_CODE, 1'b0});
            n++;
        end
        else if (r < 92)
        begin
            pending_items.push_back('{8'($urandom_range(255)), 1'b1});
            n++;
        end
        return n;
    endfunction

    // a phase of at least the line depth in items opens with a long line that may overrun the store
    task automatic fill_phase(input int count);
        int queued;
        @(negedge clk);
        queued = (count >= LINE_DEPTH_DEF) ? queue_line(1'b1) : 0;
        while (queued < count)
        begin
            if ($urandom_range(99) < 10)
            begin
                queue_item(8'($urandom_range(255)), $urandom_range(3) == 0);
                queued++;
            end
            else
            begin
                queued += queue_line($urandom_range(99) < 6);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, no idling
        set_idle(0, 0);
        queue_item(NEWLINE_CODE, 1'b0);
        queue_item(8'hFF, 1'b1);
        queue_item(ERASE_RESET, 1'b0);
        queue_item(8'h00, 1'b1);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item("a", 1'b0);
        queue_item(ERASE_RESET, 1'b0);
        queue_item("b", 1'b0);
        queue_item(NEWLINE_CODE, 1'b0);
        queue_item("c", 1'b0);
        queue_item("d", 1'b0);
        queue_item(KILL_RESET, 1'b0);
        queue_item("e", 1'b0);
        queue_item(NEWLINE_CODE, 1'b1);
        queue_item(ERASE_RESET, 1'b1);
        queue_item("f", 1'b0);
        queue_item(KILL_RESET, 1'b0);
        queue_item(ERASE_RESET, 1'b0);
        queue_item(NEWLINE_CODE, 1'b0);
        fill_phase(64);
        drain_block();

        // extremes, sender idling, pause between two phases
        write_reg(CFG_ERASE, 8'h00);
        write_reg(CFG_KILL, 8'hFF);
        write_reg(CFG_SPARE, 8'h5A);
        settings_used++;
        set_idle(46, 0);
        fill_phase(20);
        drain_block();
        fill_phase(20);
        drain_block();

        // erase and kill equal, receiver stalling
        write_reg(CFG_ERASE, 8'h41);
        write_reg(CFG_KILL, 8'h41);
        settings_used++;
        set_idle(0, 46);
        fill_phase(64);
        drain_block();

        // registers hold newline, both sides idling
        write_reg(CFG_ERASE, NEWLINE_CODE);
        write_reg(CFG_KILL, NEWLINE_CODE);
        settings_used++;
        set_idle(21, 21);
        fill_phase(30);
        drain_block();

        // opposite extremes, no idling
        write_reg(CFG_ERASE, 8'hFF);
        write_reg(CFG_KILL, 8'h00);
        settings_used++;
        set_idle(0, 0);
        fill_phase(30);
        drain_block();

        // random registers, both sides idling
        write_reg(CFG_ERASE, 8'($urandom_range(255)));
        write_reg(CFG_KILL, 8'($urandom_range(255)));
        write_reg(CFG_SPARE + 2'd1, 8'($urandom_range(255)));
        settings_used++;
        set_idle(21, 21);
        fill_phase(30);
        drain_block();

        if (expected_emits.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_emits.size()));

        $display("Run covered %0d input items and %0d output bytes under %0d register settings",
                 items_in, bytes_out, settings_used);
        $display("Lines flushed: %0d, of which %0d overran the store", lines_out,
                 overflow_lines);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- line_edit_buffer_core.f -----
rtl/leb_pkg.sv
rtl/leb_ctrl.sv
rtl/leb_datapath.sv
rtl/line_edit_buffer_core.sv
tb/sv/tb_top.sv
